/* rtl/svpa_pkg.sv */
package svpa_pkg;

	localparam int CHANNELS_DEF   = 3;
	localparam int COUNT_BITS_DEF = 16;
	localparam int IN_CHANNELS    = 3;

	localparam int WIDTH_BITS = 16;
	localparam int ANGLE_BITS = 8;
	localparam int PCT_BITS   = 5;
	localparam int PROD_BITS  = WIDTH_BITS + ANGLE_BITS;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_COUNTER_TOP = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CAL_PCT     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_LOW   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_HIGH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_SPAN  = 3'd4;

	localparam logic [WIDTH_BITS-1:0] COUNTER_TOP_RST = 16'd3999;
	localparam logic [PCT_BITS-1:0]   CAL_PCT_RST     = 5'd5;
	localparam logic [WIDTH_BITS-1:0] WIDTH_LOW_RST   = 16'd1000;
	localparam logic [WIDTH_BITS-1:0] WIDTH_HIGH_RST  = 16'd2000;
	localparam logic [ANGLE_BITS-1:0] ANGLE_SPAN_RST  = 8'd180;

	// floor(w / 100) = floor((w >> 2) / 25) = ((w >> 2) * 20972) >> 19,
	// exact for all 16-bit w
	localparam logic [WIDTH_BITS-1:0] RECIP_100   = 16'd20972;
	localparam int                    RECIP_SHIFT = 19;
	localparam int                    QUO100_BITS = 10;

	typedef struct packed {
		logic [WIDTH_BITS-1:0] counter_top;
		logic [PCT_BITS-1:0]   calibration_pct;
		logic [WIDTH_BITS-1:0] width_low;
		logic [WIDTH_BITS-1:0] width_high;
		logic [ANGLE_BITS-1:0] angle_span;
	} svpa_cfg_t;

	typedef struct packed {
		logic                  start;
		logic [WIDTH_BITS-1:0] width;
	} svpa_req_t;

	typedef struct packed {
		logic                  done;
		logic [WIDTH_BITS-1:0] width;
		logic [ANGLE_BITS-1:0] angle;
	} svpa_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAN,
		ST_WAIT,
		ST_OUT
	} svpa_state_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_MUL,
		U_CAL,
		U_SCALE,
		U_DIV
	} svpa_unit_state_t;

endpackage

/* rtl/svpa_divider.sv */
module svpa_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [svpa_pkg::PROD_BITS-1:0]  num,
	input  logic [svpa_pkg::WIDTH_BITS-1:0] den,
	output logic                            done,
	output logic [svpa_pkg::ANGLE_BITS-1:0] quot
);
	import svpa_pkg::*;

	// quotient is known to fit ANGLE_BITS, so only that many restoring steps
	localparam int SH_BITS   = WIDTH_BITS + ANGLE_BITS - 1;
	localparam int STEP_BITS = $clog2(ANGLE_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [PROD_BITS-1:0]  rem_q;
	logic [SH_BITS-1:0]    dsh_q;
	logic [ANGLE_BITS-1:0] quot_q;

	logic [PROD_BITS-1:0] trial;
	logic                 ge;

	assign trial = PROD_BITS'(dsh_q);
	assign ge    = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(ANGLE_BITS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= {den, (ANGLE_BITS-1)'(0)};
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - trial;
			end
			quot_q <= {quot_q[ANGLE_BITS-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* rtl/svpa_angle_unit.sv */
module svpa_angle_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  svpa_pkg::svpa_cfg_t cfg,
	input  svpa_pkg::svpa_req_t req,
	output svpa_pkg::svpa_rsp_t rsp
);
	import svpa_pkg::*;

	localparam int Q_HI = RECIP_SHIFT + QUO100_BITS - 1;

	svpa_unit_state_t state_q, state_d;

	logic                  done_q;
	logic [WIDTH_BITS-1:0] w_q;
	logic [31:0]           prod_q;
	logic [WIDTH_BITS-1:0] cal_q;
	logic [ANGLE_BITS-1:0] angle_q;

	logic [WIDTH_BITS-1:0] removed;
	logic                  at_low;
	logic                  at_high;
	logic [PROD_BITS-1:0]  scale_prod;
	logic [WIDTH_BITS-1:0] den;
	logic                  div_start;
	logic                  div_done;
	logic [ANGLE_BITS-1:0] div_quot;

	assign removed    = WIDTH_BITS'(cfg.calibration_pct) * WIDTH_BITS'(prod_q[Q_HI:RECIP_SHIFT]);
	assign at_low     = cal_q <= cfg.width_low;
	assign at_high    = cal_q >= cfg.width_high;
	assign scale_prod = PROD_BITS'(cal_q - cfg.width_low) * PROD_BITS'(cfg.angle_span);
	assign den        = cfg.width_high - cfg.width_low;
	assign div_start  = (state_q == U_SCALE) && !at_low && !at_high;

	svpa_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (scale_prod),
		.den    (den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == U_SCALE) && (at_low || at_high)) ||
			           ((state_q == U_DIV) && div_done);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			U_IDLE:  if (req.start) state_d = U_MUL;
			U_MUL:   state_d = U_CAL;
			U_CAL:   state_d = U_SCALE;
			U_SCALE: state_d = (at_low || at_high) ? U_IDLE : U_DIV;
			U_DIV:   if (div_done) state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE:  if (req.start) w_q <= req.width;
			U_MUL:   prod_q <= 32'(w_q >> 2) * 32'(RECIP_100);
			U_CAL:   cal_q <= w_q - removed;
			U_SCALE: begin
				if (at_low) begin
					angle_q <= '0;
				end else if (at_high) begin
					angle_q <= cfg.angle_span;
				end
			end
			U_DIV:   if (div_done) angle_q <= div_quot;
			default: ;
		endcase
	end

	assign rsp = '{done: done_q, width: cal_q, angle: angle_q};

endmodule

/* rtl/servo_pulse_width_to_angle_core.sv */
// Channel   Signals                          Dir  Item
// s_        s_tvalid s_tready s_tdata[7:0]   in   one timer tick, three pulse levels
// m_        m_tvalid m_tready m_tdata[79:0]  out  angles, widths, update mask
// cfg_      cfg_we cfg_index cfg_wdata       in   register write, no wait
//
// A width at or beyond the limits skips the divider; the 8-step divider in the
// angle unit is shared by all channels.
// s_tready is high only while the sequencer is idle; the output register holds
// one finished item so a new tick is taken while m_ is stalled.
// Reset: asynchronous, active low; registers return to their default values,
// channel counters and edge state clear, the latched levels do not.
module servo_pulse_width_to_angle_core #(
	parameter int CHANNELS   = svpa_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = svpa_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// level_a [0], level_b [1], level_c [2], zero [7:3]
	input  logic [7:0]                         s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// angle_a [7:0], angle_b [15:8], angle_c [23:16], width_a [39:24],
	// width_b [55:40], width_c [71:56], updated_mask [74:72], zero [79:75]
	output logic [79:0]                        m_tdata,
	input  logic                               cfg_we,
	input  logic [svpa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [svpa_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import svpa_pkg::*;

	localparam int CH_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int M_FIELD_BITS = IN_CHANNELS * (ANGLE_BITS + WIDTH_BITS) + IN_CHANNELS;
	localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

	svpa_cfg_t   cfg_q;
	svpa_state_t state_q, state_d;

	logic [CH_BITS-1:0]     ch_q;
	logic [IN_CHANNELS-1:0] mask_q;
	logic [CHANNELS-1:0]    lvl_q;
	logic [CHANNELS-1:0]    prev_q;
	logic [CHANNELS-1:0]    armed_q;
	logic [COUNT_BITS-1:0]  cnt_q        [CHANNELS];
	logic [WIDTH_BITS-1:0]  last_width_q [CHANNELS];
	logic [ANGLE_BITS-1:0]  last_angle_q [CHANNELS];
	logic                   m_tvalid_q;
	logic [M_TDATA_BITS-1:0] m_tdata_q;

	logic                  cur_lvl;
	logic                  cur_prev;
	logic                  cur_armed;
	logic [COUNT_BITS-1:0] cnt_adv;
	logic [31:0]           cnt32;
	logic [WIDTH_BITS-1:0] sat_width;
	logic                  rise_arm;
	logic                  capture;
	logic                  last_ch;
	logic                  accept;
	logic                  out_load;

	svpa_req_t req;
	svpa_rsp_t rsp;

	logic [ANGLE_BITS-1:0] ang_out [IN_CHANNELS];
	logic [WIDTH_BITS-1:0] wid_out [IN_CHANNELS];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{counter_top: COUNTER_TOP_RST, calibration_pct: CAL_PCT_RST,
			           width_low: WIDTH_LOW_RST, width_high: WIDTH_HIGH_RST,
			           angle_span: ANGLE_SPAN_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNTER_TOP: cfg_q.counter_top     <= cfg_wdata[WIDTH_BITS-1:0];
				REG_CAL_PCT:     cfg_q.calibration_pct <= cfg_wdata[PCT_BITS-1:0];
				REG_WIDTH_LOW:   cfg_q.width_low       <= cfg_wdata[WIDTH_BITS-1:0];
				REG_WIDTH_HIGH:  cfg_q.width_high      <= cfg_wdata[WIDTH_BITS-1:0];
				REG_ANGLE_SPAN:  cfg_q.angle_span      <= cfg_wdata[ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// per-channel tick logic, one channel per cycle unless a capture waits for the angle unit
	assign cur_lvl   = lvl_q[ch_q];
	assign cur_prev  = prev_q[ch_q];
	assign cur_armed = armed_q[ch_q];
	assign cnt_adv   = (32'(cnt_q[ch_q]) >= 32'(cfg_q.counter_top)) ? '0
	                 : cnt_q[ch_q] + COUNT_BITS'(1);
	assign cnt32     = 32'(cnt_adv);
	assign sat_width = (cnt32 > 32'h0000_FFFF) ? '1 : cnt32[WIDTH_BITS-1:0];
	assign rise_arm  = cur_lvl & ~cur_prev & ~cur_armed;
	assign capture   = ~cur_lvl & cur_prev & cur_armed;
	assign last_ch   = ch_q == CH_BITS'(CHANNELS - 1);

	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	assign req = '{start: (state_q == ST_CHAN) && capture, width: sat_width};

	svpa_angle_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_CHAN;
			end
			ST_CHAN: begin
				if (capture) begin
					state_d = ST_WAIT;
				end else if (last_ch) begin
					state_d = ST_OUT;
				end
			end
			ST_WAIT: if (rsp.done) state_d = last_ch ? ST_OUT : ST_CHAN;
			ST_OUT:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ch_q       <= '0;
			mask_q     <= '0;
			prev_q     <= '0;
			armed_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				cnt_q[i]        <= '0;
				last_width_q[i] <= '0;
				last_angle_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				ch_q   <= '0;
				mask_q <= '0;
			end
			if (state_q == ST_CHAN) begin
				cnt_q[ch_q]  <= rise_arm ? '0 : cnt_adv;
				prev_q[ch_q] <= cur_lvl;
				if (rise_arm) armed_q[ch_q] <= 1'b1;
				if (capture)  armed_q[ch_q] <= 1'b0;
				if (!capture && !last_ch) ch_q <= ch_q + 1'b1;
			end
			if ((state_q == ST_WAIT) && rsp.done) begin
				last_width_q[ch_q] <= rsp.width;
				last_angle_q[ch_q] <= rsp.angle;
				// channels past the three outputs leave no mark
				mask_q <= mask_q | (3'b001 << ch_q);
				if (!last_ch) ch_q <= ch_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// levels of channels past the inputs stay low
	always_ff @(posedge clk) begin
		if (accept) lvl_q <= CHANNELS'(s_tdata[IN_CHANNELS-1:0]);
	end

	for (genvar g = 0; g < IN_CHANNELS; g++) begin : g_out
		if (g < CHANNELS) begin : g_live
			assign ang_out[g] = last_angle_q[g];
			assign wid_out[g] = last_width_q[g];
		end else begin : g_none
			assign ang_out[g] = '0;
			assign wid_out[g] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= M_TDATA_BITS'({mask_q, wid_out[2], wid_out[1], wid_out[0],
			                            ang_out[2], ang_out[1], ang_out[0]});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == ST_WAIT)
		else $error("angle unit finished outside wait state");

	a_accept_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CHAN && ch_q == '0 && mask_q == '0))
		else $error("sequencer did not restart at channel zero");

	a_out_last_ch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> last_ch)
		else $error("output loaded before last channel");
`endif

endmodule
